/* rtl/midi_pitch_scale_quantizer_assert.svh */
// assertion macros shared by the pitch scale quantizer modules
`ifndef MIDI_PITCH_SCALE_QUANTIZER_ASSERT_SVH
`define MIDI_PITCH_SCALE_QUANTIZER_ASSERT_SVH

// same-cycle implication, checked on clk, off while in reset
`define MPSQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpsq assertion failed");

// next-cycle implication, checked on clk, off while in reset
`define MPSQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpsq assertion failed");

`endif

/* rtl/mpsq_pkg.sv */
// shared types, constants and functions of the pitch scale quantizer
package mpsq_pkg;

	localparam int unsigned NUM_SEMI   = 12;
	localparam int unsigned CFG_W      = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam logic [6:0]  NOTE_MAX   = 7'd127;
	localparam logic [2:0]  DIST_NONE  = 3'd7;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE   = 2'd2;

	// preset scale codes
	localparam logic [3:0] PRE_MAJOR      = 4'd0;
	localparam logic [3:0] PRE_MINOR      = 4'd1;
	localparam logic [3:0] PRE_HARMONIC   = 4'd2;
	localparam logic [3:0] PRE_MELODIC    = 4'd3;
	localparam logic [3:0] PRE_DORIAN     = 4'd4;
	localparam logic [3:0] PRE_PHRYGIAN   = 4'd5;
	localparam logic [3:0] PRE_LYDIAN     = 4'd6;
	localparam logic [3:0] PRE_MIXOLYDIAN = 4'd7;
	localparam logic [3:0] PRE_PENT_MAJ   = 4'd8;
	localparam logic [3:0] PRE_PENT_MIN   = 4'd9;

	// reset values of the registers
	localparam logic [11:0] RST_CUSTOM_MASK = 12'h001;
	localparam logic [3:0]  RST_PRESET      = PRE_MAJOR;
	localparam logic [3:0]  RST_TRANSPOSE   = 4'd0;

	// word handed from cell to cell
	typedef struct packed {
		logic [3:0] semi;
		logic [3:0] octave;
		logic [2:0] gap;
		logic [3:0] note;
	} mpsq_word_t;

	// preset scale as a semitone set; codes past blues fall back to blues
	function automatic logic [11:0] preset_mask(input logic [3:0] idx);
		logic [11:0] m;
		case (idx)
			PRE_MAJOR:      m = 12'hAB5;
			PRE_MINOR:      m = 12'h5AD;
			PRE_HARMONIC:   m = 12'h9AD;
			PRE_MELODIC:    m = 12'hAAD;
			PRE_DORIAN:     m = 12'h6AD;
			PRE_PHRYGIAN:   m = 12'h5AB;
			PRE_LYDIAN:     m = 12'hAD5;
			PRE_MIXOLYDIAN: m = 12'h6B5;
			PRE_PENT_MAJ:   m = 12'h295;
			PRE_PENT_MIN:   m = 12'h4A9;
			default:        m = 12'h4E9;
		endcase
		return m;
	endfunction

	// note / 12 for a 7-bit note: multiply by 43, drop 9 bits
	function automatic logic [3:0] div12(input logic [6:0] n);
		logic [12:0] p;
		p = 13'(n) * 13'd43;
		return p[12:9];
	endfunction

endpackage

/* rtl/mpsq_front.sv */
// entry stage: splits the note into octave and semitone and applies transpose
module mpsq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [6:0]          raw_pitch,
	input  logic [3:0]          transpose,
	output logic                vld,
	output mpsq_pkg::mpsq_word_t word
);
	import mpsq_pkg::*;

	logic [3:0] oct_base;
	logic [3:0] rem;
	logic [4:0] sum;
	logic [3:0] semi;
	logic [3:0] carry;
	logic       vld_s1;
	mpsq_word_t word_s1;

	// octave and semitone of the raw note, plus transpose with octave carry
	always_comb begin
		oct_base = div12(raw_pitch);
		rem      = 4'(raw_pitch - 7'({oct_base, 3'b000} + {1'b0, oct_base, 2'b00}));
		sum      = 5'(rem) + 5'(transpose);
		if (sum >= 5'd24) begin
			semi  = 4'(sum - 5'd24);
			carry = 4'd2;
		end else if (sum >= 5'd12) begin
			semi  = 4'(sum - 5'd12);
			carry = 4'd1;
		end else begin
			semi  = sum[3:0];
			carry = 4'd0;
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	// word register, no best candidate yet
	always_ff @(posedge clk) begin
		word_s1.semi   <= semi;
		word_s1.octave <= oct_base + carry;
		word_s1.gap    <= DIST_NONE;
		word_s1.note   <= 4'd0;
	end

	assign vld  = vld_s1;
	assign word = word_s1;

endmodule

/* rtl/mpsq_cell.sv */
// one cell of the chain: tests one semitone against the best so far
module mpsq_cell #(
	parameter logic [3:0] CAND = 4'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                member,
	input  logic                vld_i,
	input  mpsq_pkg::mpsq_word_t word_i,
	output logic                vld_o,
	output mpsq_pkg::mpsq_word_t word_o
);
	import mpsq_pkg::*;

	logic [3:0] diff;
	logic [2:0] cand_gap;
	logic       vld_q;
	mpsq_word_t word_q;
	mpsq_word_t word_nxt;

	// wrapped distance from this semitone to the target
	always_comb begin
		diff = (CAND > word_i.semi) ? (CAND - word_i.semi) : (word_i.semi - CAND);
		if (diff > 4'd6) begin
			cand_gap = 3'(4'd12 - diff);
		end else begin
			cand_gap = diff[2:0];
		end
		word_nxt = word_i;
		// strictly closer only, so a lower semitone keeps a tie
		if (member && (cand_gap < word_i.gap)) begin
			word_nxt.gap  = cand_gap;
			word_nxt.note = CAND;
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	// word register
	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign vld_o  = vld_q;
	assign word_o = word_q;

`include "midi_pitch_scale_quantizer_assert.svh"

	// best distance never grows along the chain
	`MPSQ_ASSERT_IMP(a_dist_mono, vld_q, word_q.gap <= $past(word_i.gap))
	// target semitone passes through untouched; only the semitone is checked
	`MPSQ_ASSERT_IMP(a_pass, vld_q, word_q.semi == $past(word_i.semi))

endmodule

/* rtl/mpsq_out.sv */
// output stage: rebuilds the note from octave and chosen semitone, clamps it
module mpsq_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_i,
	input  mpsq_pkg::mpsq_word_t word_i,
	output logic                done,
	output logic [6:0]          quantized_note
);
	import mpsq_pkg::*;

	logic [7:0] note_full;
	logic       done_q;
	logic [6:0] note_q;

	// octave * 12 + semitone, clamp to the top note
	always_comb begin
		note_full = {1'b0, word_i.octave, 3'b000} + {2'b00, word_i.octave, 2'b00}
			+ 8'(word_i.note);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_i;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		note_q <= (note_full > 8'(NOTE_MAX)) ? NOTE_MAX : note_full[6:0];
	end

	assign done           = done_q;
	assign quantized_note = note_q;

`include "midi_pitch_scale_quantizer_assert.svh"

	// every scale has at least one semitone, so a match is always found
	`MPSQ_ASSERT_IMP(a_found, vld_i, word_i.gap <= 3'd6)

endmodule

/* rtl/midi_pitch_scale_quantizer.sv */
// top level of the midi pitch scale quantizer
//
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+-------------------------
//  note in  | start, raw_pitch, busy           | in        | start high, busy low
//  note out | done, quantized_note             | out       | one-cycle strobe on done
//  config   | cfg_we, cfg_addr, cfg_wdata      | in        | write when cfg_we high
//
// a word is taken every cycle; busy is never raised
// pipeline: entry stage, twelve semitone cells, output stage
// the twelve-cell chain sets the latency, one cell per scale semitone
// reset clears the pipeline valid flags and loads the register defaults
// the result cannot be stalled; it is shown for exactly one cycle
module midi_pitch_scale_quantizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [6:0]                     raw_pitch,
	output logic                           busy,
	output logic                           done,
	output logic [6:0]                     quantized_note,
	input  logic                           cfg_we,
	input  logic [mpsq_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [mpsq_pkg::CFG_W-1:0]     cfg_wdata
);
	import mpsq_pkg::*;

	localparam int unsigned LATENCY = NUM_SEMI + 2;

	logic [11:0] custom_mask_q;
	logic [3:0]  preset_q;
	logic [3:0]  transpose_q;
	logic [11:0] scale_mask;
	logic        take;

	logic        vld  [0:NUM_SEMI];
	mpsq_word_t  word [0:NUM_SEMI];

	assign busy = 1'b0;
	assign take = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			custom_mask_q <= RST_CUSTOM_MASK;
			preset_q      <= RST_PRESET;
			transpose_q   <= RST_TRANSPOSE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CUSTOM_MASK: custom_mask_q <= cfg_wdata[11:0];
				REG_PRESET:      preset_q      <= cfg_wdata[3:0];
				REG_TRANSPOSE:   transpose_q   <= cfg_wdata[3:0];
				default:         ;
			endcase
		end
	end

	// active scale: custom set when any bit is on, else the preset
	assign scale_mask = (custom_mask_q != 12'd0) ? custom_mask_q : preset_mask(preset_q);

	mpsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.raw_pitch (raw_pitch),
		.transpose (transpose_q),
		.vld       (vld[0]),
		.word      (word[0])
	);

	// chain of semitone cells, lowest semitone first
	for (genvar g = 0; g < NUM_SEMI; g++) begin : g_cell
		mpsq_cell #(
			.CAND (4'(g))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.member (scale_mask[g]),
			.vld_i  (vld[g]),
			.word_i (word[g]),
			.vld_o  (vld[g+1]),
			.word_o (word[g+1])
		);
	end

	mpsq_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.vld_i          (vld[NUM_SEMI]),
		.word_i         (word[NUM_SEMI]),
		.done           (done),
		.quantized_note (quantized_note)
	);

`include "midi_pitch_scale_quantizer_assert.svh"

	// each result strobe traces back to a word that was taken
	`MPSQ_ASSERT_IMP(a_latency, done, $past(take, LATENCY))
	// a taken word is in the entry stage on the next cycle
	`MPSQ_ASSERT_NXT(a_enter, take, vld[0])

endmodule

/* verif/tb_midi_pitch_scale_quantizer.sv */
// self-checking testbench for the midi pitch scale quantizer: directed table, then random phases
module tb_midi_pitch_scale_quantizer;
	import mpsq_pkg::*;

	localparam int          LATENCY        = 14;
	localparam int          RANDOM_ITEMS   = 1200;
	localparam int          DRAIN_LIMIT    = 2000;
	localparam int          TIMEOUT_CYCLES = 300000;
	localparam int          NO_CHECK       = -1;
	localparam int          DIRECTED_ROWS  = 25;
	localparam logic [3:0]  PRESET_BLUES   = 4'd10;

	// one row of the directed table: settings, note in, and a typed result where obvious
	typedef struct {
		logic [11:0] mask;
		logic [3:0]  preset;
		logic [3:0]  shift;
		logic [6:0]  pitch;
		int          want;
	} note_row_t;

	typedef struct {
		logic [6:0] pitch;
		logic [6:0] note;
	} note_exp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [6:0]           raw_pitch = 7'd0;
	logic                 busy;
	logic                 done;
	logic [6:0]           quantized_note;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = REG_CUSTOM_MASK;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	note_exp_t   expected_notes[$];
	note_exp_t   head_note;
	note_row_t   directed_rows[DIRECTED_ROWS];
	int          note_errors = 0;
	bit          gaps_on = 1'b1;

	// settings the block holds right now
	logic [11:0] cur_mask   = RST_CUSTOM_MASK;
	logic [3:0]  cur_preset = RST_PRESET;
	logic [3:0]  cur_shift  = RST_TRANSPOSE;

	midi_pitch_scale_quantizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.raw_pitch      (raw_pitch),
		.busy           (busy),
		.done           (done),
		.quantized_note (quantized_note),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// semitone set of each preset, bit i is semitone i
	function automatic logic [11:0] preset_scale_set(input logic [3:0] preset);
		logic [11:0] set;
		case (preset)
			PRE_MAJOR:      set = 12'b1010_1011_0101;
			PRE_MINOR:      set = 12'b0101_1010_1101;
			PRE_HARMONIC:   set = 12'b1001_1010_1101;
			PRE_MELODIC:    set = 12'b1010_1010_1101;
			PRE_DORIAN:     set = 12'b0110_1010_1101;
			PRE_PHRYGIAN:   set = 12'b0101_1010_1011;
			PRE_LYDIAN:     set = 12'b1010_1101_0101;
			PRE_MIXOLYDIAN: set = 12'b0110_1011_0101;
			PRE_PENT_MAJ:   set = 12'b0010_1001_0101;
			PRE_PENT_MIN:   set = 12'b0100_1010_1001;
			// blues, and every code past it
			default:        set = 12'b0100_1110_1001;
		endcase
		return set;
	endfunction

	// nearest scale semitone by wrapped distance, lower one on a tie, octave left as is
	function automatic logic [6:0] snap_to_scale(input logic [6:0] pitch, input logic [11:0] mask,
			input logic [3:0] preset, input logic [3:0] shift);
		logic [11:0] scale;
		int          semi_sum;
		int          octave;
		int          semi;
		int          best;
		int          best_gap;
		int          gap;
		int          note;
		scale = (mask != 12'h000) ? mask : preset_scale_set(preset);
		semi_sum = int'(pitch) % 12 + int'(shift);
		octave = int'(pitch) / 12 + semi_sum / 12;
		semi = semi_sum % 12;
		best = 0;
		best_gap = 12;
		for (int i = 0; i < 12; i++) begin
			if (scale[i]) begin
				gap = (i > semi) ? i - semi : semi - i;
				if (gap > 6)
					gap = 12 - gap;
				if (gap < best_gap) begin
					best_gap = gap;
					best = i;
				end
			end
		end
		note = octave * 12 + best;
		if (note > 127)
			note = 127;
		return 7'(note);
	endfunction

	task automatic note_fault(input string what, input int pitch, input int want, input int got);
		note_errors++;
		if (note_errors <= 10)
			$display("%s: pitch %0d expected %0d got %0d", what, pitch, want, got);
	endtask

	// result checker: every strobe is matched to the oldest expected word
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_notes.size() == 0) begin
				note_fault("unexpected word", -1, -1, quantized_note);
			end else begin
				head_note = expected_notes.pop_front();
				if (quantized_note !== head_note.note)
					note_fault("quantized_note mismatch", head_note.pitch, head_note.note,
						quantized_note);
			end
		end
	end

	// offer one note, with random gaps; leaves start high for the next word
	task automatic send_note(input logic [6:0] pitch, input int want);
		note_exp_t exp_word;
		while (gaps_on && $urandom_range(0, 99) < 26) begin
			start <= 1'b0;
			raw_pitch <= 7'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		raw_pitch <= pitch;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		exp_word.pitch = pitch;
		exp_word.note = (want == NO_CHECK) ?
			snap_to_scale(pitch, cur_mask, cur_preset, cur_shift) : 7'(want);
		expected_notes.push_back(exp_word);
	endtask

	// wait until every expected word has come back, then let the pipe empty
	task automatic settle();
		for (int n = 0; expected_notes.size() != 0 && n < DRAIN_LIMIT; n++)
			@(posedge clk);
		repeat (LATENCY + 2)
			@(posedge clk);
	endtask

	// write all three registers back to back while the block is idle
	task automatic load_settings(input logic [11:0] mask, input logic [3:0] preset,
			input logic [3:0] shift);
		cfg_we <= 1'b1;
		cfg_addr <= REG_CUSTOM_MASK;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_addr <= REG_PRESET;
		cfg_wdata <= CFG_W'(preset);
		@(posedge clk);
		cfg_addr <= REG_TRANSPOSE;
		cfg_wdata <= CFG_W'(shift);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mask = mask;
		cur_preset = preset;
		cur_shift = shift;
	endtask

	// run limit
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin
		logic [11:0] mask;
		logic [3:0]  preset;
		logic [3:0]  shift;
		logic [6:0]  pitch;
		int          sent;
		int          phase;
		int          len;

		directed_rows = '{
			// reset settings: one-note scale, both pitch extremes, the six-semitone edge
			'{12'h001, PRE_MAJOR, 4'd0, 7'd0, 0},
			'{12'h001, PRE_MAJOR, 4'd0, 7'd127, 120},
			'{12'h001, PRE_MAJOR, 4'd0, 7'd6, 0},
			// chromatic mask, transpose extremes, clamp at the top
			'{12'hFFF, PRE_MAJOR, 4'd0, 7'd0, 0},
			'{12'hFFF, PRE_MAJOR, 4'd0, 7'd127, 127},
			'{12'hFFF, PRE_MAJOR, 4'd12, 7'd127, 127},
			'{12'hFFF, PRE_MAJOR, 4'd15, 7'd11, NO_CHECK},
			'{12'hFFF, PRE_MAJOR, 4'd15, 7'd127, 127},
			// every preset
			'{12'h000, PRE_MAJOR, 4'd0, 7'd61, NO_CHECK},
			'{12'h000, PRE_MINOR, 4'd0, 7'd63, NO_CHECK},
			'{12'h000, PRE_HARMONIC, 4'd0, 7'd68, NO_CHECK},
			'{12'h000, PRE_MELODIC, 4'd0, 7'd66, NO_CHECK},
			'{12'h000, PRE_DORIAN, 4'd0, 7'd70, NO_CHECK},
			'{12'h000, PRE_PHRYGIAN, 4'd0, 7'd62, NO_CHECK},
			'{12'h000, PRE_LYDIAN, 4'd0, 7'd65, NO_CHECK},
			'{12'h000, PRE_MIXOLYDIAN, 4'd0, 7'd71, NO_CHECK},
			'{12'h000, PRE_PENT_MAJ, 4'd0, 7'd64, NO_CHECK},
			'{12'h000, PRE_PENT_MIN, 4'd0, 7'd69, NO_CHECK},
			'{12'h000, PRESET_BLUES, 4'd0, 7'd67, NO_CHECK},
			// preset codes past blues fall back to blues
			'{12'h000, 4'd11, 4'd0, 7'd66, NO_CHECK},
			'{12'h000, 4'd15, 4'd12, 7'd127, 127},
			// equal distance: lower entry wins, also across the wrap
			'{12'h014, PRE_MAJOR, 4'd0, 7'd3, 2},
			'{12'h041, PRE_MAJOR, 4'd0, 7'd9, NO_CHECK},
			// nearest entry across the octave edge keeps the octave
			'{12'h800, PRE_MAJOR, 4'd0, 7'd0, NO_CHECK},
			// transpose past twelve carries two octaves
			'{12'h000, PRESET_BLUES, 4'd13, 7'd11, NO_CHECK}
		};

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].mask != cur_mask || directed_rows[r].preset != cur_preset ||
					directed_rows[r].shift != cur_shift) begin
				start <= 1'b0;
				settle();
				load_settings(directed_rows[r].mask, directed_rows[r].preset,
					directed_rows[r].shift);
			end
			send_note(directed_rows[r].pitch, directed_rows[r].want);
		end

		// random phases, each under its own settings
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mask = 12'h000;
				4:          mask = 12'hFFF;
				5:          mask = 12'h001 << $urandom_range(0, 11);
				default:    mask = 12'($urandom);
			endcase
			preset = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(11, 15)) :
				4'($urandom_range(0, 10));
			shift = 4'($urandom_range(0, 15));
			start <= 1'b0;
			settle();
			load_settings(mask, preset, shift);
			// phases 3 and 4 run with no gaps, so words come on every cycle
			gaps_on = !(phase == 3 || phase == 4);
			len = $urandom_range(40, 120);
			repeat (len) begin
				case ($urandom_range(0, 7))
					0:       pitch = 7'd0;
					1:       pitch = 7'd127;
					default: pitch = 7'($urandom_range(0, 127));
				endcase
				send_note(pitch, NO_CHECK);
				sent++;
			end
			phase++;
		end

		start <= 1'b0;
		settle();
		if (expected_notes.size() != 0)
			note_fault("missing words", -1, expected_notes.size(), 0);
		if (note_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
